>>> sv/knc_pkg.sv
package knc_pkg;

	localparam int unsigned COUNT_WIDTH = 16;
	localparam int unsigned WIN_DEPTH   = 22;
	localparam int unsigned NODE_KINDS  = 9;
	localparam int unsigned OUT_WIDTH   = 16;
	localparam int unsigned MCNT_WIDTH  = $clog2(NODE_KINDS + 1);
	localparam int unsigned NAME_BITS   = WIN_DEPTH * 8;

	localparam logic [7:0] OPEN_PAREN = 8'h28;

	// name endings; the statement and clause endings are shared
	localparam logic [79:0] STMT_SFX   = "_statement";
	localparam logic [55:0] CLAUSE_SFX = "_clause";
	localparam logic [87:0] EXPR_SFX   = "_expression";

	typedef logic [WIN_DEPTH-1:0][7:0] win_t;
	typedef logic [COUNT_WIDTH-1:0]    count_t;
	typedef logic [MCNT_WIDTH-1:0]     mcnt_t;

	// names are right-aligned: the final character sits in the lowest byte
	localparam logic [NAME_BITS-1:0] NODE_TEXT [NODE_KINDS] = '{
		NAME_BITS'({"if", STMT_SFX}),
		NAME_BITS'({"elif", STMT_SFX}),
		NAME_BITS'({"for", STMT_SFX}),
		NAME_BITS'({"while", STMT_SFX}),
		NAME_BITS'({"try", STMT_SFX}),
		NAME_BITS'({"finally", CLAUSE_SFX}),
		NAME_BITS'({"case", CLAUSE_SFX}),
		NAME_BITS'("assert"),
		NAME_BITS'({"conditional", EXPR_SFX})
	};

	localparam int unsigned NODE_LEN [NODE_KINDS] = '{
		12, 14, 13, 15, 13, 14, 11, 6, 22
	};

	typedef struct packed {
		logic       fire;
		logic       last;
		logic [7:0] chr;
	} step_t;

endpackage

>>> sv/keyword_node_counter_unit.sv
// Counts control-construct nodes in syntax tree text streamed one character per
// transfer: every open parenthesis directly followed by one of nine node names
// (the if, elif, for, while and try statements, the finally and case clauses,
// assert, and the conditional expression) counts once (a name that is only a
// prefix, such as assert in assert_statement, counts too). The character marked
// with tlast closes the text: one result transfer carries the count plus one,
// saturating at 65535, and the next character starts a new text. One character is
// taken every cycle; the result is set by the input register and the result
// register around the 22-character window compare. Only a final character waits
// when an earlier result has not yet been taken.
module keyword_node_counter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // [15:0] complexity
);

	knc_pkg::step_t step;
	logic           out_free;

	assign out_free = !m_axis_tvalid || m_axis_tready;

	knc_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_chr   (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.out_free (out_free),
		.step     (step)
	);

	knc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata)
	);

	// the result is never below one
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata != 16'd0))
		else $error("zero complexity result");

	// a closing character always lands a result
	assert property (@(posedge clk) disable iff (!arst_n)
		(step.fire && step.last) |=> m_axis_tvalid)
		else $error("final character gave no result");

	// input stalls only behind a final character blocked by the result side
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (step.last && m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without cause");

	// a result slot is never overwritten while still pending
	assert property (@(posedge clk) disable iff (!arst_n)
		(step.fire && step.last) |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result overwritten");

endmodule

>>> sv/knc_in_stage.sv
module knc_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_chr,
	input  logic       in_last,
	input  logic       out_free,
	output knc_pkg::step_t step
);

	logic       valid_s1;
	logic       last_s1;
	logic [7:0] chr_s1;
	logic       advance;

	// a non-final character never waits on the result side
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			chr_s1  <= in_chr;
			last_s1 <= in_last;
		end
	end

	assign step.fire = advance;
	assign step.last = last_s1;
	assign step.chr  = chr_s1;

endmodule

>>> sv/knc_match.sv
module knc_match (
	input  knc_pkg::win_t  win,
	input  logic [7:0]     chr,
	output knc_pkg::mcnt_t hits
);

	logic [knc_pkg::NODE_KINDS-1:0] hit;

	always_comb begin
		for (int n = 0; n < knc_pkg::NODE_KINDS; n++) begin
			hit[n] = (chr == knc_pkg::NODE_TEXT[n][7:0]);
			for (int k = 0; k < knc_pkg::WIN_DEPTH; k++) begin
				if (k + 1 < knc_pkg::NODE_LEN[n]) begin
					hit[n] = hit[n] && (win[k] == knc_pkg::NODE_TEXT[n][8*(k+1) +: 8]);
				end else if (k + 1 == knc_pkg::NODE_LEN[n]) begin
					hit[n] = hit[n] && (win[k] == knc_pkg::OPEN_PAREN);
				end
			end
		end
	end

	always_comb begin
		hits = '0;
		for (int n = 0; n < knc_pkg::NODE_KINDS; n++) begin
			hits = hits + knc_pkg::mcnt_t'(hit[n]);
		end
	end

endmodule

>>> sv/knc_core.sv
module knc_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  knc_pkg::step_t                 step,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [knc_pkg::OUT_WIDTH-1:0]  out_data
);

	localparam int unsigned CW = knc_pkg::COUNT_WIDTH;

	knc_pkg::win_t   win_q;
	knc_pkg::count_t count_q;
	knc_pkg::mcnt_t  hits;
	logic [CW:0]     sum;
	knc_pkg::count_t count_new;
	logic [CW:0]     res_sum;
	knc_pkg::count_t res_sat;
	logic [32:0]     res_ext;
	logic [knc_pkg::OUT_WIDTH-1:0] result;
	logic            out_valid_q;
	logic [knc_pkg::OUT_WIDTH-1:0] out_data_q;

	knc_match u_match (
		.win  (win_q),
		.chr  (step.chr),
		.hits (hits)
	);

	always_comb begin
		sum       = {1'b0, count_q} + (CW+1)'(hits);
		count_new = sum[CW] ? '1 : sum[CW-1:0];
		res_sum   = {1'b0, count_new} + (CW+1)'(1);
		res_sat   = res_sum[CW] ? '1 : res_sum[CW-1:0];
		res_ext   = 33'(res_sat);
		result    = (res_ext > 33'({knc_pkg::OUT_WIDTH{1'b1}})) ? '1
			: res_ext[knc_pkg::OUT_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			count_q <= '0;
		end else if (step.fire) begin
			if (step.last) begin
				win_q   <= '0;
				count_q <= '0;
			end else begin
				win_q   <= {win_q[knc_pkg::WIN_DEPTH-2:0], step.chr};
				count_q <= count_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step.fire && step.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step.fire && step.last) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> sim/keyword_node_counter_unit_tb.sv
`timescale 1ns / 1ps

module keyword_node_counter_unit_tb;

	localparam int unsigned RUN_LIMIT = 50_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] char_in
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;           // [15:0] complexity

	string           node_names [knc_pkg::NODE_KINDS];
	logic [7:0]      text_window [knc_pkg::WIN_DEPTH];
	knc_pkg::count_t node_count;
	logic [15:0]     complexity_q [$];
	logic [7:0]      txt_buf [$];
	logic [15:0]     wanted_complexity;

	bit          idle_on = 1'b0;
	int          rx_hold_left = 0;
	int          rx_gap_left = 0;
	int          chars_sent = 0;
	int          err_count = 0;
	int unsigned cycle_cnt = 0;

	keyword_node_counter_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= RUN_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// node name text, first character first
	function automatic string node_text(input int n);
		string s;
		int k;
		s = "";
		for (k = int'(knc_pkg::NODE_LEN[n]) - 1; k >= 0; k--)
			s = {s, string'(knc_pkg::NODE_TEXT[n][8*k +: 8])};
		return s;
	endfunction

	// node counting model
	function automatic bit name_ends_here(input string nm, input logic [7:0] c);
		int len;
		int k;
		len = nm.len();
		if (len > knc_pkg::WIN_DEPTH || c != nm[len-1])
			return 1'b0;
		for (k = 0; k < len - 1; k++)
			if (text_window[k] != nm[len-2-k])
				return 1'b0;
		return text_window[len-1] == knc_pkg::OPEN_PAREN;
	endfunction

	function automatic void clear_text_state();
		int i;
		for (i = 0; i < knc_pkg::WIN_DEPTH; i++)
			text_window[i] = 8'h00;
		node_count = '0;
	endfunction

	function automatic void count_char(input logic [7:0] c, input logic lst);
		int n;
		int i;
		for (n = 0; n < knc_pkg::NODE_KINDS; n++)
			if (name_ends_here(node_names[n], c) && node_count != '1)
				node_count = node_count + 1'b1;
		for (i = knc_pkg::WIN_DEPTH - 1; i > 0; i--)
			text_window[i] = text_window[i-1];
		text_window[0] = c;
		if (lst) begin
			complexity_q.push_back((node_count == '1) ? 16'hFFFF : 16'(node_count + 1'b1));
			clear_text_state();
		end
	endfunction

	// result checking
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (complexity_q.size() == 0) begin
				$display("%0t: result with none pending, expected none actual %0d",
					$time, m_axis_tdata);
				err_count++;
			end else begin
				wanted_complexity = complexity_q.pop_front();
				if (m_axis_tdata !== wanted_complexity) begin
					$display("%0t: complexity mismatch, expected %0d actual %0d",
						$time, wanted_complexity, m_axis_tdata);
					err_count++;
				end
			end
		end
	end

	// result side ready with holds and random gaps
	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold_left = rx_hold_left - 1;
		end else if (rx_gap_left > 0) begin
			m_axis_tready <= 1'b0;
			rx_gap_left = rx_gap_left - 1;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			m_axis_tready <= 1'b0;
			rx_gap_left = $urandom_range(0, 4);
		end else
			m_axis_tready <= 1'b1;
	end

	task automatic send_char(input logic [7:0] c, input logic lst);
		int gap;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= lst;
		do
			@(posedge clk);
		while (!s_axis_tready);
		count_char(c, lst);
		chars_sent++;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_buf();
		int i;
		for (i = 0; i < txt_buf.size(); i++)
			send_char(txt_buf[i], i == txt_buf.size() - 1);
		txt_buf.delete();
	endtask

	task automatic put_str(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			txt_buf.push_back(s[i]);
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (complexity_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic add_fragment();
		int kind;
		int pos;
		string nm;
		kind = $urandom_range(0, 9);
		nm = node_names[$urandom_range(0, knc_pkg::NODE_KINDS - 1)];
		case (kind)
			0, 1, 2, 3: begin
				txt_buf.push_back(knc_pkg::OPEN_PAREN);
				put_str(nm);
				put_str($urandom_range(0, 1) ? " " : ")");
			end
			4: begin
				txt_buf.push_back(knc_pkg::OPEN_PAREN);
				put_str(nm);
				put_str("_statement");
			end
			5: put_str(nm);
			6: begin
				txt_buf.push_back(knc_pkg::OPEN_PAREN);
				put_str(nm.substr(0, $urandom_range(0, nm.len() - 2)));
			end
			7: begin
				txt_buf.push_back(knc_pkg::OPEN_PAREN);
				put_str(nm);
				pos = txt_buf.size() - nm.len() + $urandom_range(0, nm.len() - 1);
				txt_buf[pos] = 8'($urandom_range(0, 255));
			end
			8: repeat ($urandom_range(1, 4)) txt_buf.push_back(8'($urandom_range(0, 255)));
			default: put_str($urandom_range(0, 1) ? "((" : " (");
		endcase
	endtask

	task automatic test_directed();
		int n;
		txt_buf.push_back(8'h00);
		txt_buf.push_back(8'hFF);
		send_buf();
		put_str("(");
		send_buf();
		put_str("assert");
		send_buf();
		put_str("(asser");
		send_buf();
		put_str("(assert");
		send_buf();
		for (n = 0; n < knc_pkg::NODE_KINDS; n++) begin
			txt_buf.push_back(knc_pkg::OPEN_PAREN);
			put_str(node_names[n]);
			if (n % 2 == 0)
				put_str(" ");
		end
		put_str(")");
		send_buf();
		put_str("(assert_statement)");
		send_buf();
		put_str("((");
		put_str(node_names[knc_pkg::NODE_KINDS - 1]);
		send_buf();
		put_str("xx(");
		send_buf();
		put_str("assert");
		send_buf();
		drain();
	endtask

	task automatic test_random(input int n_chars);
		int stop_at;
		stop_at = chars_sent + n_chars;
		while (chars_sent < stop_at) begin
			if ($urandom_range(0, 7) == 0)
				txt_buf.push_back(8'($urandom_range(0, 255)));
			else
				repeat ($urandom_range(1, 5)) add_fragment();
			send_buf();
		end
		drain();
	endtask

	task automatic test_backpressure();
		int i;
		rx_hold_left = 300;
		for (i = 0; i < 40; i++) begin
			repeat ($urandom_range(1, 3)) txt_buf.push_back(8'($urandom_range(0, 255)));
			send_buf();
		end
		drain();
	endtask

	initial begin
		int n;
		for (n = 0; n < knc_pkg::NODE_KINDS; n++)
			node_names[n] = node_text(n);
		clear_text_state();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		idle_on = 1'b1;
		test_directed();
		test_random(150);
		test_backpressure();
		idle_on = 1'b0;
		test_random(110);
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> keyword_node_counter_unit.f
sv/knc_pkg.sv
sv/knc_in_stage.sv
sv/knc_match.sv
sv/knc_core.sv
sv/keyword_node_counter_unit.sv
sim/keyword_node_counter_unit_tb.sv
